@@ rtl/core/stsh_pkg.sv @@
// Shared types, constants and helper functions of the stereo angle level histogram.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package stsh_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int SQ_W         = 32;
    localparam int RAD_W        = 16;
    localparam int BIN_W        = 6;
    localparam int BCNT_W       = 7;
    localparam int MAX_BINS     = 64;
    localparam int LEVEL_W      = 30;
    localparam int COUNT_W      = 13;
    localparam int OUT_LVL_W    = 15;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;
    localparam int CORDIC_W     = 28;
    localparam int ANG_W        = 18;
    localparam int THETA_W      = 16;
    localparam int PROD_W       = THETA_W + BCNT_W;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 8;

    localparam logic [COUNT_W-1:0]   MAX_BLOCK   = COUNT_W'(4096);
    localparam logic [LEVEL_W-1:0]   SUM_MAX     = {LEVEL_W{1'b1}};
    localparam logic [OUT_LVL_W-1:0] CLIP_LEVEL  = OUT_LVL_W'(31130);
    localparam logic [THETA_W-1:0]   SILENT_ANG  = THETA_W'(49152);
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(16384);

    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MODE = CFG_IDX_W'(1);

    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_AVG = 1'b1;

    typedef struct packed {
        logic                rd_en;
        logic [BIN_W-1:0]    rd_addr;
        logic                wr_en;
        logic [BIN_W-1:0]    wr_addr;
        logic                clear;
    } store_req_t;

    function automatic logic signed [ANG_W-1:0] cordic_atan(input logic [STEP_W-1:0] step);
        logic signed [ANG_W-1:0] a;
        unique case (step)
            4'd0:    a = ANG_W'(16384);
            4'd1:    a = ANG_W'(9672);
            4'd2:    a = ANG_W'(5110);
            4'd3:    a = ANG_W'(2594);
            4'd4:    a = ANG_W'(1302);
            4'd5:    a = ANG_W'(652);
            4'd6:    a = ANG_W'(326);
            4'd7:    a = ANG_W'(163);
            4'd8:    a = ANG_W'(81);
            4'd9:    a = ANG_W'(41);
            4'd10:   a = ANG_W'(20);
            4'd11:   a = ANG_W'(10);
            4'd12:   a = ANG_W'(5);
            4'd13:   a = ANG_W'(3);
            4'd14:   a = ANG_W'(1);
            default: a = ANG_W'(1);
        endcase
        return a;
    endfunction

    function automatic logic [OUT_LVL_W-1:0] clip_level(input logic [LEVEL_W-1:0] v);
        logic [OUT_LVL_W-1:0] r;
        if (v > LEVEL_W'(CLIP_LEVEL))
        begin
            r = CLIP_LEVEL;
        end
        else
        begin
            r = v[OUT_LVL_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/stereo_angle_level_histogram.sv @@
// Top level of the stereo angle level histogram: control sequencer, ports, config.
// Depends on stsh_pkg, stsh_polar, stsh_div, stsh_store.
//
//   port group  | dir | fields (low bit up)
//   s_axis_*    | in  | tdata: left_sample[15:0], right_sample[31:16]; tlast: block_end
//   m_axis_*    | out | tdata: bin_index[5:0], bin_level[20:6], zero[23:21]; tlast: level_last
//   cfg_*       | in  | cfg_index: register, cfg_data: value
//
// Each pair passes through the polar unit (square, sum, 16-step radius/CORDIC iteration,
// bin mapping, hand-off), then the store read-modify-write, and back to idle before the
// next pair is accepted. A block end adds a readout: per bin a store read, a wait and an
// output load, plus a 16-step divider run for non-empty bins in average mode. Reset
// clears the store at once through valid bits. Input is held off during work; the last
// result may wait in the output register while the next pair is taken.
`timescale 1ns / 1ps

module stereo_angle_level_histogram (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [31:0]                        s_axis_tdata,  // left_sample, right_sample
    input  logic                               s_axis_tlast,  // block_end
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [23:0]                        m_axis_tdata,  // bin_index, bin_level, zero pad
    output logic                               m_axis_tlast,  // level_last
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [stsh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stsh_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import stsh_pkg::*;

    typedef enum logic [7:0] {
        T_IDLE   = 8'b00000001,
        T_POLAR  = 8'b00000010,
        T_READ   = 8'b00000100,
        T_MODIFY = 8'b00001000,
        T_ERD    = 8'b00010000,
        T_EWAIT  = 8'b00100000,
        T_EDIV   = 8'b01000000,
        T_ELOAD  = 8'b10000000
    } top_state_t;

    top_state_t state_reg, state_next;

    logic [BCNT_W-1:0]    bin_count_reg;
    logic                 mode_reg;
    logic                 last_reg;
    logic [BIN_W-1:0]     bin_reg, idx_reg;
    logic [RAD_W-1:0]     rad_reg;
    logic [OUT_LVL_W-1:0] lvl_reg;
    logic                 out_valid_reg;
    logic [BIN_W-1:0]     out_idx_reg;
    logic [OUT_LVL_W-1:0] out_lvl_reg;
    logic                 out_last_reg;

    logic [BCNT_W-1:0]    n_bins;
    logic                 in_take, polar_done, div_done, div_start;
    logic [RAD_W-1:0]     polar_rad, div_q;
    logic [BIN_W-1:0]     polar_bin;
    store_req_t           req;
    logic [LEVEL_W-1:0]   rd_level, wr_level;
    logic [COUNT_W-1:0]   rd_count, wr_count;
    logic [LEVEL_W:0]     sum_ext;
    logic                 out_free, is_last_bin;

    always_comb
    begin
        priority if (bin_count_reg == '0)
        begin
            n_bins = BCNT_W'(1);
        end
        else if (bin_count_reg > BCNT_W'(MAX_BINS))
        begin
            n_bins = BCNT_W'(MAX_BINS);
        end
        else
        begin
            n_bins = bin_count_reg;
        end
    end

    assign s_axis_tready = (state_reg == T_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign is_last_bin   = ({1'b0, idx_reg} == (n_bins - BCNT_W'(1)));
    assign sum_ext       = {1'b0, rd_level} + (LEVEL_W+1)'(rad_reg);
    assign div_start     = (state_reg == T_EWAIT) && (mode_reg == MODE_AVG) && (rd_count != '0);

    stsh_polar u_polar (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_take),
        .left_sample  (s_axis_tdata[15:0]),
        .right_sample (s_axis_tdata[31:16]),
        .n_bins       (n_bins),
        .done         (polar_done),
        .radius       (polar_rad),
        .bin          (polar_bin)
    );

    stsh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_level),
        .divisor  (rd_count),
        .done     (div_done),
        .quotient (div_q)
    );

    stsh_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .wr_level (wr_level),
        .wr_count (wr_count),
        .rd_level (rd_level),
        .rd_count (rd_count)
    );

    always_comb
    begin
        req.rd_en   = (state_reg == T_READ) || (state_reg == T_ERD);
        req.rd_addr = (state_reg == T_READ) ? bin_reg : idx_reg;
        req.wr_addr = bin_reg;
        req.wr_en   = 1'b0;
        req.clear   = (state_reg == T_ELOAD) && out_free && is_last_bin;
        wr_level    = rd_level;
        wr_count    = rd_count;
        if (state_reg == T_MODIFY)
        begin
            if (mode_reg == MODE_MAX)
            begin
                req.wr_en = LEVEL_W'(rad_reg) > rd_level;
                wr_level  = LEVEL_W'(rad_reg);
            end
            else
            begin
                req.wr_en = rd_count < MAX_BLOCK;
                wr_level  = sum_ext[LEVEL_W] ? SUM_MAX : sum_ext[LEVEL_W-1:0];
                wr_count  = rd_count + COUNT_W'(1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:   if (in_take) state_next = T_POLAR;
            T_POLAR:  if (polar_done) state_next = T_READ;
            T_READ:   state_next = T_MODIFY;
            T_MODIFY: state_next = last_reg ? T_ERD : T_IDLE;
            T_ERD:    state_next = T_EWAIT;
            T_EWAIT:  state_next = div_start ? T_EDIV : T_ELOAD;
            T_EDIV:   if (div_done) state_next = T_ELOAD;
            T_ELOAD:
            begin
                if (out_free)
                begin
                    state_next = is_last_bin ? T_IDLE : T_ERD;
                end
            end
            default:  state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            bin_count_reg <= BCNT_W'(MAX_BINS);
            mode_reg      <= MODE_MAX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_BIN_COUNT)
                begin
                    bin_count_reg <= cfg_data[BCNT_W-1:0];
                end
                else if (cfg_index == REG_LEVEL_MODE)
                begin
                    mode_reg <= cfg_data[0];
                end
            end
            if (state_reg == T_ELOAD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            last_reg <= s_axis_tlast;
        end
        if (state_reg == T_POLAR && polar_done)
        begin
            bin_reg <= polar_bin;
            rad_reg <= polar_rad;
        end
        if (state_reg == T_MODIFY)
        begin
            idx_reg <= '0;
        end
        if (state_reg == T_EWAIT && !div_start)
        begin
            lvl_reg <= (mode_reg == MODE_AVG) ? '0 : clip_level(rd_level);
        end
        if (state_reg == T_EDIV && div_done)
        begin
            lvl_reg <= clip_level(LEVEL_W'(div_q));
        end
        if (state_reg == T_ELOAD && out_free)
        begin
            out_idx_reg  <= idx_reg;
            out_lvl_reg  <= lvl_reg;
            out_last_reg <= is_last_bin;
            idx_reg      <= idx_reg + BIN_W'(1);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_lvl_reg, out_idx_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ rtl/core/stsh_polar.sv @@
// Iterative polar unit: exact integer radius and CORDIC direction, mapped to a bin.
// Depends on stsh_pkg.
`timescale 1ns / 1ps

module stsh_polar (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [stsh_pkg::SAMPLE_W-1:0] left_sample,
    input  logic signed [stsh_pkg::SAMPLE_W-1:0] right_sample,
    input  logic [stsh_pkg::BCNT_W-1:0]       n_bins,
    output logic                              done,
    output logic [stsh_pkg::RAD_W-1:0]        radius,
    output logic [stsh_pkg::BIN_W-1:0]        bin
);
    import stsh_pkg::*;

    typedef enum logic [5:0] {
        P_IDLE = 6'b000001,
        P_SQ   = 6'b000010,
        P_SUM  = 6'b000100,
        P_ITER = 6'b001000,
        P_BIN  = 6'b010000,
        P_OUT  = 6'b100000
    } polar_state_t;

    polar_state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] l_reg, r_reg;
    logic [SQ_W-1:0]            lsq_reg, rsq_reg;
    logic [SQ_W-1:0]            v_reg, res_reg, bit_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg;
    logic signed [ANG_W-1:0]    z_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       silent_reg;
    logic [PROD_W-1:0]          prod_reg;

    logic signed [SAMPLE_W:0]   lx, rx, lf, rf;
    logic signed [SAMPLE_W+8:0] x0, y0;
    logic [SQ_W-1:0]            trial;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [ANG_W-1:0]    ang;
    logic [THETA_W-1:0]         theta;
    logic [BCNT_W-1:0]          bin_raw, bin_top;

    assign lx = {l_reg[SAMPLE_W-1], l_reg};
    assign rx = {r_reg[SAMPLE_W-1], r_reg};
    assign lf = l_reg[SAMPLE_W-1] ? -lx : lx;
    assign rf = l_reg[SAMPLE_W-1] ? -rx : rx;
    assign x0 = {lf, 8'd0};
    assign y0 = {rf, 8'd0};
    assign trial = res_reg + bit_reg;
    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign ang = -z_reg - QUARTER_TURN;
    assign theta = silent_reg ? SILENT_ANG : ang[THETA_W-1:0];
    assign bin_raw = prod_reg[PROD_W-1:THETA_W];
    assign bin_top = n_bins - BCNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            P_IDLE: if (start) state_next = P_SQ;
            P_SQ:   state_next = P_SUM;
            P_SUM:  state_next = P_ITER;
            P_ITER: if (step_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = P_BIN;
            P_BIN:  state_next = P_OUT;
            P_OUT:  state_next = P_IDLE;
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    l_reg <= left_sample;
                    r_reg <= right_sample;
                end
            end
            P_SQ:
            begin
                lsq_reg <= SQ_W'(l_reg * l_reg);
                rsq_reg <= SQ_W'(r_reg * r_reg);
                silent_reg <= (l_reg == '0) && (r_reg == '0);
            end
            P_SUM:
            begin
                v_reg    <= lsq_reg + rsq_reg;
                res_reg  <= '0;
                bit_reg  <= SQ_W'(32'h4000_0000);
                x_reg    <= CORDIC_W'(x0);
                y_reg    <= CORDIC_W'(y0);
                z_reg    <= '0;
                step_reg <= '0;
            end
            P_ITER:
            begin
                if (v_reg >= trial)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + cordic_atan(step_reg);
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - cordic_atan(step_reg);
                end
                step_reg <= step_reg + STEP_W'(1);
            end
            P_BIN:
            begin
                prod_reg <= PROD_W'(theta * n_bins);
            end
            default:
            begin
            end
        endcase
    end

    assign done   = (state_reg == P_OUT);
    assign radius = res_reg[RAD_W-1:0];
    assign bin    = (bin_raw > bin_top) ? bin_top[BIN_W-1:0] : bin_raw[BIN_W-1:0];

endmodule

@@ rtl/core/stsh_div.sv @@
// Restoring divider for the average level: one quotient bit per cycle.
// Depends on stsh_pkg.
`timescale 1ns / 1ps

module stsh_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [stsh_pkg::LEVEL_W-1:0]  dividend,
    input  logic [stsh_pkg::COUNT_W-1:0]  divisor,
    output logic                          done,
    output logic [stsh_pkg::RAD_W-1:0]    quotient
);
    import stsh_pkg::*;

    localparam int REM_W = LEVEL_W - RAD_W;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_DONE = 3'b100
    } div_state_t;

    div_state_t state_reg, state_next;

    logic [REM_W-1:0]  rem_reg;
    logic [RAD_W-1:0]  lo_reg, q_reg;
    logic [COUNT_W-1:0] dvs_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [REM_W:0]    sh;
    logic              take;

    assign sh   = {rem_reg, lo_reg[RAD_W-1]};
    assign take = sh >= (REM_W+1)'(dvs_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE: if (start) state_next = D_RUN;
            D_RUN:  if (cnt_reg == STEP_W'(RAD_W - 1)) state_next = D_DONE;
            D_DONE: state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && start)
        begin
            rem_reg <= dividend[LEVEL_W-1:RAD_W];
            lo_reg  <= dividend[RAD_W-1:0];
            dvs_reg <= divisor;
            q_reg   <= '0;
            cnt_reg <= '0;
        end
        else if (state_reg == D_RUN)
        begin
            rem_reg <= take ? REM_W'(sh - (REM_W+1)'(dvs_reg)) : sh[REM_W-1:0];
            lo_reg  <= lo_reg << 1;
            q_reg   <= {q_reg[RAD_W-2:0], take};
            cnt_reg <= cnt_reg + STEP_W'(1);
        end
    end

    assign done     = (state_reg == D_DONE);
    assign quotient = q_reg;

endmodule

@@ rtl/core/stsh_store.sv @@
// Bin store: level and count memories with registered read and per-entry valid bits.
// Depends on stsh_pkg.
`timescale 1ns / 1ps

module stsh_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stsh_pkg::store_req_t          req,
    input  logic [stsh_pkg::LEVEL_W-1:0]  wr_level,
    input  logic [stsh_pkg::COUNT_W-1:0]  wr_count,
    output logic [stsh_pkg::LEVEL_W-1:0]  rd_level,
    output logic [stsh_pkg::COUNT_W-1:0]  rd_count
);
    import stsh_pkg::*;

    logic [LEVEL_W-1:0]  level_mem [MAX_BINS];
    logic [COUNT_W-1:0]  count_mem [MAX_BINS];
    logic [MAX_BINS-1:0] valid_reg;
    logic                rd_valid_reg;
    logic [LEVEL_W-1:0]  rd_level_reg;
    logic [COUNT_W-1:0]  rd_count_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            level_mem[req.wr_addr] <= wr_level;
            count_mem[req.wr_addr] <= wr_count;
        end
        if (req.rd_en)
        begin
            rd_level_reg <= level_mem[req.rd_addr];
            rd_count_reg <= count_mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_level = rd_valid_reg ? rd_level_reg : '0;
    assign rd_count = rd_valid_reg ? rd_count_reg : '0;

endmodule
